[sv/brf_pkg.sv]
// Package for the banked register file: request codes, mode and bank
// encodings, reset values and the condition-code evaluator.
// No dependencies.
`default_nettype none

package brf_pkg;

  // Request function codes
  typedef enum logic [2:0] {
    FUNC_READ_REG   = 3'd0,
    FUNC_WRITE_REG  = 3'd1,
    FUNC_READ_CPSR  = 3'd2,
    FUNC_WRITE_CPSR = 3'd3,
    FUNC_READ_SPSR  = 3'd4,
    FUNC_WRITE_SPSR = 3'd5,
    FUNC_TEST_COND  = 3'd6
  } func_t;

  // Register bank indexes for r13, r14 and the SPSR
  typedef enum logic [2:0] {
    BANK_DEFAULT = 3'd0,
    BANK_FIQ     = 3'd1,
    BANK_SVC     = 3'd2,
    BANK_ABT     = 3'd3,
    BANK_IRQ     = 3'd4,
    BANK_UND     = 3'd5
  } bank_t;

  localparam int unsigned NUM_BANKS   = 6;
  localparam int unsigned NUM_GENERAL = 13;
  localparam int unsigned NUM_FIQ_HI  = 5;

  // CPSR mode field codes
  localparam logic [4:0] MODE_FAST_IRQ   = 5'h11;
  localparam logic [4:0] MODE_NORMAL_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC        = 5'h13;
  localparam logic [4:0] MODE_ABT        = 5'h17;
  localparam logic [4:0] MODE_UND        = 5'h1B;

  // Register numbers with special handling
  localparam logic [3:0] REG_FIQ_LO = 4'd8;
  localparam logic [3:0] REG_FIQ_HI = 4'd12;
  localparam logic [3:0] REG_SP     = 4'd13;
  localparam logic [3:0] REG_LR     = 4'd14;
  localparam logic [3:0] REG_PC     = 4'd15;

  localparam int unsigned THUMB_BIT = 5;

  // Reset values
  localparam logic [31:0] SP_RESET   = 32'h0300_7F00;
  localparam logic [31:0] LR_RESET   = 32'h0800_0000;
  localparam logic [31:0] CPSR_RESET = 32'h0000_005F;
  localparam logic [31:0] ARM_ALIGN  = 32'hFFFF_FFFC;

  // Condition codes
  typedef enum logic [3:0] {
    COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
    COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
    COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
    COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
  } cond_t;

  // Map the CPSR mode field to its bank; unknown modes use the default bank
  function automatic bank_t bank_of_mode(input logic [4:0] mode);
    bank_t bank;
    case (mode)
      MODE_FAST_IRQ:   bank = BANK_FIQ;
      MODE_SVC:        bank = BANK_SVC;
      MODE_ABT:        bank = BANK_ABT;
      MODE_NORMAL_IRQ: bank = BANK_IRQ;
      MODE_UND:        bank = BANK_UND;
      default:         bank = BANK_DEFAULT;
    endcase
    return bank;
  endfunction

  // Evaluate a condition against the N, Z, C, V flags (CPSR[31:28])
  function automatic logic cond_holds(input logic [3:0] flags, input cond_t code);
    logic n, z, c, v, pass;
    n = flags[3];
    z = flags[2];
    c = flags[1];
    v = flags[0];
    case (code)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = c;
      COND_CC: pass = !c;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = c && !z;
      COND_LS: pass = !c || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

`default_nettype wire

[sv/banked_register_file.sv]
// Banked register file top level: r0-r15 with FIQ and per-mode banks,
// CPSR, per-mode SPSR and a condition tester. Depends on brf_pkg.
`default_nettype none

// The result is registered in the output register at the edge that accepts the request.
// Throughput: one request per cycle; a request is taken whenever the output
// register is empty or its result is being taken in the same cycle.
// State updates land at the accepting edge, so the next request sees them.
// Reset loads all register banks, the PC and the CPSR with their reset values; SPSRs and result data are not reset.
module banked_register_file (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [3:0]  reg_index,
  input  wire logic [31:0] write_value,
  input  wire logic [3:0]  cond_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic             cond_pass,
  output logic             refill_request
);

  // Architectural state
  logic [31:0] general_regs [brf_pkg::NUM_GENERAL];
  logic [31:0] fiq_high_regs [brf_pkg::NUM_FIQ_HI];
  logic [31:0] stack_ptr_bank [brf_pkg::NUM_BANKS];
  logic [31:0] link_reg_bank [brf_pkg::NUM_BANKS];
  logic [31:0] saved_status_bank [brf_pkg::NUM_BANKS];
  logic [31:0] program_counter;
  logic [31:0] current_status;

  // Decode of the current request
  brf_pkg::func_t func_req;
  brf_pkg::bank_t bank;
  logic           accept;
  logic           fiq_mode;
  logic           fiq_hi_sel;
  logic [2:0]     fiq_idx;
  logic [31:0]    reg_rd;
  logic [31:0]    pc_next;
  logic [31:0]    read_data_next;
  logic           cond_pass_next;
  logic           refill_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign func_req = brf_pkg::func_t'(func);
  assign bank     = brf_pkg::bank_of_mode(current_status[4:0]);
  assign fiq_mode = (current_status[4:0] == brf_pkg::MODE_FAST_IRQ);
  assign fiq_hi_sel = fiq_mode && (reg_index >= brf_pkg::REG_FIQ_LO)
                      && (reg_index <= brf_pkg::REG_FIQ_HI);
  assign fiq_idx  = reg_index[2:0];

  // PC write value: ARM state word-aligns, thumb state clears bit 0
  assign pc_next = write_value[0] ? {write_value[31:1], 1'b0}
                                  : (write_value & brf_pkg::ARM_ALIGN);

  // Register read mux
  always_comb begin
    if (fiq_hi_sel) begin
      reg_rd = fiq_high_regs[fiq_idx];
    end else if (reg_index < brf_pkg::REG_SP) begin
      reg_rd = general_regs[reg_index];
    end else if (reg_index == brf_pkg::REG_SP) begin
      reg_rd = stack_ptr_bank[bank];
    end else if (reg_index == brf_pkg::REG_LR) begin
      reg_rd = link_reg_bank[bank];
    end else begin
      reg_rd = program_counter;
    end
  end

  // Result of the request
  always_comb begin
    read_data_next = '0;
    cond_pass_next = 1'b0;
    refill_next    = 1'b0;
    case (func_req)
      brf_pkg::FUNC_READ_REG:  read_data_next = reg_rd;
      brf_pkg::FUNC_WRITE_REG: refill_next = !fiq_hi_sel && (reg_index == brf_pkg::REG_PC);
      brf_pkg::FUNC_READ_CPSR: read_data_next = current_status;
      brf_pkg::FUNC_READ_SPSR: read_data_next = saved_status_bank[bank];
      brf_pkg::FUNC_TEST_COND:
        cond_pass_next = brf_pkg::cond_holds(current_status[31:28],
                                             brf_pkg::cond_t'(cond_code));
      default: ;
    endcase
  end

  // State updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brf_pkg::NUM_GENERAL; i++) general_regs[i] <= '0;
      for (int i = 0; i < brf_pkg::NUM_FIQ_HI; i++) fiq_high_regs[i] <= '0;
      for (int i = 0; i < brf_pkg::NUM_BANKS; i++) begin
        stack_ptr_bank[i] <= '0;
        link_reg_bank[i]  <= '0;
      end
      stack_ptr_bank[brf_pkg::BANK_DEFAULT] <= brf_pkg::SP_RESET;
      link_reg_bank[brf_pkg::BANK_DEFAULT]  <= brf_pkg::LR_RESET;
      program_counter <= '0;
      current_status  <= brf_pkg::CPSR_RESET;
    end else if (accept) begin
      case (func_req)
        brf_pkg::FUNC_WRITE_REG: begin
          if (fiq_hi_sel) begin
            fiq_high_regs[fiq_idx] <= write_value;
          end else if (reg_index < brf_pkg::REG_SP) begin
            general_regs[reg_index] <= write_value;
          end else if (reg_index == brf_pkg::REG_SP) begin
            stack_ptr_bank[bank] <= write_value;
          end else if (reg_index == brf_pkg::REG_LR) begin
            link_reg_bank[bank] <= write_value;
          end else begin
            program_counter <= pc_next;
            current_status[brf_pkg::THUMB_BIT] <= write_value[0];
          end
        end
        brf_pkg::FUNC_WRITE_CPSR: current_status <= write_value;
        default: ;
      endcase
    end
  end

  // SPSR bank: no reset, contents undefined until written
  always_ff @(posedge clk) begin
    if (accept && (func_req == brf_pkg::FUNC_WRITE_SPSR)) begin
      saved_status_bank[bank] <= write_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= read_data_next;
      cond_pass      <= cond_pass_next;
      refill_request <= refill_next;
    end
  end

endmodule

`default_nettype wire

[tb/banked_register_file_tb.sv]
// Self-checking testbench for banked_register_file: directed and random register,
// status and condition requests, checked against a predictor of the banked state.
// Depends on brf_pkg and banked_register_file.
`default_nettype none

module banked_register_file_tb;

  localparam logic [2:0] FUNC_UNUSED   = 3'd7;
  localparam int RANDOM_PER_PHASE      = 410;
  localparam int WATCHDOG_LIMIT        = 2000;
  localparam int DRAIN_CYCLES          = 10;
  localparam int REPORT_LIMIT          = 10;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [3:0]  cond;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        cond_pass;
    logic        refill;
  } access_result_t;

  // Scoreboard: keeps its own copy of the banked state and the results due
  class regfile_scoreboard;
    logic [31:0] gen_regs[brf_pkg::NUM_GENERAL];
    logic [31:0] fiq_regs[brf_pkg::NUM_FIQ_HI];
    logic [31:0] sp_bank[brf_pkg::NUM_BANKS];
    logic [31:0] lr_bank[brf_pkg::NUM_BANKS];
    logic [31:0] spsr_bank[brf_pkg::NUM_BANKS];
    bit          spsr_valid[brf_pkg::NUM_BANKS];
    logic [31:0] pc;
    logic [31:0] cpsr;
    access_result_t results_due[$];
    int errors;
    int func_seen[8];
    int refills;
    int cond_passes;
    int modes_seen[brf_pkg::NUM_BANKS];

    function new();
      foreach (gen_regs[i]) gen_regs[i] = '0;
      foreach (fiq_regs[i]) fiq_regs[i] = '0;
      foreach (sp_bank[i]) begin
        sp_bank[i]    = '0;
        lr_bank[i]    = '0;
        spsr_bank[i]  = '0;
        spsr_valid[i] = 1'b0;
        modes_seen[i] = 0;
      end
      sp_bank[brf_pkg::BANK_DEFAULT] = brf_pkg::SP_RESET;
      lr_bank[brf_pkg::BANK_DEFAULT] = brf_pkg::LR_RESET;
      pc          = '0;
      cpsr        = brf_pkg::CPSR_RESET;
      errors      = 0;
      refills     = 0;
      cond_passes = 0;
      foreach (func_seen[i]) func_seen[i] = 0;
    endfunction

    function brf_pkg::bank_t mode_bank();
      case (cpsr[4:0])
        brf_pkg::MODE_FAST_IRQ:   return brf_pkg::BANK_FIQ;
        brf_pkg::MODE_NORMAL_IRQ: return brf_pkg::BANK_IRQ;
        brf_pkg::MODE_SVC:        return brf_pkg::BANK_SVC;
        brf_pkg::MODE_ABT:        return brf_pkg::BANK_ABT;
        brf_pkg::MODE_UND:        return brf_pkg::BANK_UND;
        default:                  return brf_pkg::BANK_DEFAULT;
      endcase
    endfunction

    function bit in_fiq_high(logic [3:0] idx);
      return cpsr[4:0] == brf_pkg::MODE_FAST_IRQ && idx >= brf_pkg::REG_FIQ_LO
             && idx <= brf_pkg::REG_FIQ_HI;
    endfunction

    function bit spsr_ready();
      return spsr_valid[mode_bank()];
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function logic [31:0] reg_value(logic [3:0] idx);
      if (in_fiq_high(idx)) return fiq_regs[idx - brf_pkg::REG_FIQ_LO];
      if (idx < brf_pkg::REG_SP) return gen_regs[idx];
      if (idx == brf_pkg::REG_SP) return sp_bank[mode_bank()];
      if (idx == brf_pkg::REG_LR) return lr_bank[mode_bank()];
      return pc;
    endfunction

    // Returns 1 when the write hit r15
    function logic reg_store(logic [3:0] idx, logic [31:0] v);
      if (in_fiq_high(idx)) fiq_regs[idx - brf_pkg::REG_FIQ_LO] = v;
      else if (idx < brf_pkg::REG_SP) gen_regs[idx] = v;
      else if (idx == brf_pkg::REG_SP) sp_bank[mode_bank()] = v;
      else if (idx == brf_pkg::REG_LR) lr_bank[mode_bank()] = v;
      else begin
        // bit 0 selects thumb state; ARM state forces word alignment
        cpsr[brf_pkg::THUMB_BIT] = v[0];
        v[0] = 1'b0;
        if (!cpsr[brf_pkg::THUMB_BIT]) v = v & brf_pkg::ARM_ALIGN;
        pc = v;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic flags_meet(logic [3:0] code);
      logic n, z, c, v;
      n = cpsr[31];
      z = cpsr[30];
      c = cpsr[29];
      v = cpsr[28];
      case (code)
        brf_pkg::COND_EQ: return z;
        brf_pkg::COND_NE: return !z;
        brf_pkg::COND_CS: return c;
        brf_pkg::COND_CC: return !c;
        brf_pkg::COND_MI: return n;
        brf_pkg::COND_PL: return !n;
        brf_pkg::COND_VS: return v;
        brf_pkg::COND_VC: return !v;
        brf_pkg::COND_HI: return c && !z;
        brf_pkg::COND_LS: return !c || z;
        brf_pkg::COND_GE: return n == v;
        brf_pkg::COND_LT: return n != v;
        brf_pkg::COND_GT: return !z && (n == v);
        brf_pkg::COND_LE: return z || (n != v);
        brf_pkg::COND_AL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Accepted request: update the state and queue the result it must produce
    function void note_request(access_t a);
      access_result_t r;
      r = '0;
      func_seen[a.func]++;
      modes_seen[mode_bank()]++;
      case (a.func)
        brf_pkg::FUNC_READ_REG:   r.read_data = reg_value(a.idx);
        brf_pkg::FUNC_WRITE_REG:  r.refill = reg_store(a.idx, a.value);
        brf_pkg::FUNC_READ_CPSR:  r.read_data = cpsr;
        brf_pkg::FUNC_WRITE_CPSR: cpsr = a.value;
        brf_pkg::FUNC_READ_SPSR:  r.read_data = spsr_bank[mode_bank()];
        brf_pkg::FUNC_WRITE_SPSR: begin
          spsr_bank[mode_bank()]  = a.value;
          spsr_valid[mode_bank()] = 1'b1;
        end
        brf_pkg::FUNC_TEST_COND:  r.cond_pass = flags_meet(a.cond);
        default: ;
      endcase
      if (r.refill) refills++;
      if (r.cond_pass) cond_passes++;
      results_due.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("MISMATCH %s: expected 0x%08h, got 0x%08h", what, exp_v, act_v);
    endfunction

    // Accepted result: compare with the oldest result due
    function void check_result(access_result_t got);
      access_result_t want;
      if (results_due.size() == 0) begin
        flag("unexpected result, read_data", '0, got.read_data);
        return;
      end
      want = results_due.pop_front();
      if (got.read_data !== want.read_data) flag("read_data", want.read_data, got.read_data);
      if (got.cond_pass !== want.cond_pass)
        flag("cond_pass", 32'(want.cond_pass), 32'(got.cond_pass));
      if (got.refill !== want.refill)
        flag("refill_request", 32'(want.refill), 32'(got.refill));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [3:0]  reg_index = '0;
  logic [31:0] write_value = '0;
  logic [3:0]  cond_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        cond_pass;
  logic        refill_request;

  int send_idle_pct = 33;
  int recv_idle_pct = 52;
  int requests_taken = 0;
  int results_taken = 0;
  int idle_cycles = 0;

  regfile_scoreboard sb = new();

  banked_register_file dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .reg_index      (reg_index),
    .write_value    (write_value),
    .cond_code      (cond_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .cond_pass      (cond_pass),
    .refill_request (refill_request)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Handshake monitor: results first, then the newly accepted request
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result({read_data, cond_pass, refill_request});
        results_taken++;
      end
      if (in_valid && !in_stall) begin
        sb.note_request({func, reg_index, write_value, cond_code});
        requests_taken++;
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("banked_register_file_tb: done, errors");
    $finish;
  end

  // Drive one request at a falling edge and hold it until taken
  task automatic issue_request(input logic [2:0] f, input logic [3:0] idx,
                               input logic [31:0] val, input logic [3:0] code);
    int taken_before;
    taken_before = requests_taken;
    func        <= f;
    reg_index   <= idx;
    write_value <= val;
    cond_code   <= code;
    in_valid    <= 1'b1;
    do @(negedge clk); while (requests_taken == taken_before);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Hold off the sender until every result due has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Mostly mode-valid traffic with random data; SPSR reads only once written
  task automatic random_request();
    int pick;
    logic [2:0]  f;
    logic [3:0]  idx;
    logic [3:0]  code;
    logic [31:0] val;
    logic [4:0]  modes[7];
    modes = '{brf_pkg::MODE_FAST_IRQ, brf_pkg::MODE_NORMAL_IRQ, brf_pkg::MODE_SVC,
              brf_pkg::MODE_ABT, brf_pkg::MODE_UND, 5'h10, 5'h1F};
    pick = $urandom_range(99);
    idx  = 4'($urandom_range(15));
    code = 4'($urandom_range(15));
    case ($urandom_range(7))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    if (pick < 30) f = brf_pkg::FUNC_READ_REG;
    else if (pick < 55) f = brf_pkg::FUNC_WRITE_REG;
    else if (pick < 60) f = brf_pkg::FUNC_READ_CPSR;
    else if (pick < 72) begin
      f = brf_pkg::FUNC_WRITE_CPSR;
      val = $urandom;
      if ($urandom_range(99) < 85) val[4:0] = modes[$urandom_range(6)];
    end
    else if (pick < 78) f = brf_pkg::FUNC_READ_SPSR;
    else if (pick < 85) f = brf_pkg::FUNC_WRITE_SPSR;
    else if (pick < 97) f = brf_pkg::FUNC_TEST_COND;
    else f = FUNC_UNUSED;
    if (f == brf_pkg::FUNC_READ_SPSR && !sb.spsr_ready()) f = brf_pkg::FUNC_WRITE_SPSR;
    issue_request(f, idx, val, code);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset values and PC handling
    issue_request(brf_pkg::FUNC_READ_REG, 4'd0, '0, '0);
    issue_request(brf_pkg::FUNC_READ_REG, brf_pkg::REG_SP, '0, '0);
    issue_request(brf_pkg::FUNC_READ_REG, brf_pkg::REG_LR, '0, '0);
    issue_request(brf_pkg::FUNC_READ_REG, brf_pkg::REG_PC, '0, '0);
    issue_request(brf_pkg::FUNC_READ_CPSR, '0, '0, '0);
    // system mode uses the default SPSR entry
    issue_request(brf_pkg::FUNC_WRITE_SPSR, '0, 32'hFFFF_FFFF, '0);
    issue_request(brf_pkg::FUNC_READ_SPSR, '0, '0, '0);
    // odd PC enters thumb state, only bit 0 cleared
    issue_request(brf_pkg::FUNC_WRITE_REG, brf_pkg::REG_PC, 32'hFFFF_FFFF, '0);
    issue_request(brf_pkg::FUNC_READ_REG, brf_pkg::REG_PC, '0, '0);
    // even PC returns to ARM state, word aligned
    issue_request(brf_pkg::FUNC_WRITE_REG, brf_pkg::REG_PC, 32'h0000_0002, '0);
    issue_request(brf_pkg::FUNC_READ_CPSR, '0, '0, '0);
    // FIQ mode with all flags set: banked r8..r12 and r13
    issue_request(brf_pkg::FUNC_WRITE_CPSR, '0, {4'hF, 23'd0, brf_pkg::MODE_FAST_IRQ}, '0);
    issue_request(brf_pkg::FUNC_WRITE_REG, brf_pkg::REG_FIQ_LO, 32'hFFFF_FFFF, '0);
    issue_request(brf_pkg::FUNC_WRITE_REG, brf_pkg::REG_FIQ_HI, 32'h5555_5555, '0);
    issue_request(brf_pkg::FUNC_READ_REG, brf_pkg::REG_FIQ_LO, '0, '0);
    issue_request(brf_pkg::FUNC_WRITE_REG, brf_pkg::REG_SP, 32'hAAAA_AAAA, '0);
    issue_request(brf_pkg::FUNC_TEST_COND, '0, '0, brf_pkg::COND_NV);
    issue_request(brf_pkg::FUNC_TEST_COND, '0, '0, brf_pkg::COND_AL);
    issue_request(brf_pkg::FUNC_TEST_COND, '0, '0, brf_pkg::COND_EQ);
    // unknown mode falls back to the default bank
    issue_request(brf_pkg::FUNC_WRITE_CPSR, '0, 32'h0000_0005, '0);
    issue_request(brf_pkg::FUNC_READ_REG, brf_pkg::REG_SP, '0, '0);
    issue_request(brf_pkg::FUNC_TEST_COND, '0, '0, brf_pkg::COND_NE);
    issue_request(FUNC_UNUSED, 4'hF, 32'hFFFF_FFFF, 4'hF);
    // supervisor SPSR
    issue_request(brf_pkg::FUNC_WRITE_CPSR, '0, {27'd0, brf_pkg::MODE_SVC}, '0);
    issue_request(brf_pkg::FUNC_WRITE_SPSR, '0, 32'h1234_5678, '0);
    issue_request(brf_pkg::FUNC_READ_SPSR, '0, '0, '0);
    drain_results();

    // Random phases: receiver-heavy idling, sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 33 : 0;
      repeat (RANDOM_PER_PHASE) random_request();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.flag("results never returned", sb.pending(), '0);

    $display("covered %0d requests, %0d results: %0d reg reads, %0d reg writes, %0d refills",
             requests_taken, results_taken, sb.func_seen[brf_pkg::FUNC_READ_REG],
             sb.func_seen[brf_pkg::FUNC_WRITE_REG], sb.refills);
    $display("status: %0d cpsr writes, %0d spsr reads, %0d cond tests (%0d passed), %0d unused",
             sb.func_seen[brf_pkg::FUNC_WRITE_CPSR], sb.func_seen[brf_pkg::FUNC_READ_SPSR],
             sb.func_seen[brf_pkg::FUNC_TEST_COND], sb.cond_passes,
             sb.func_seen[FUNC_UNUSED]);
    if (sb.errors == 0) begin
      $display("banked_register_file_tb: done, clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("banked_register_file_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/brf_pkg.sv
sv/banked_register_file.sv
tb/banked_register_file_tb.sv
